[design/skf_pkg.sv]
// Shared types and constants of the scalar Kalman filter.
package skf_pkg;

    localparam int unsigned GAIN_W = 17;
    localparam int unsigned ACC_W  = 51;
    localparam int unsigned OPA_W  = 34;

    localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;

    localparam logic [1:0] REG_PROCESS_NOISE      = 2'd0;
    localparam logic [1:0] REG_MEASUREMENT_NOISE  = 2'd1;
    localparam logic [1:0] REG_INITIAL_COVARIANCE = 2'd2;
    localparam logic [1:0] REG_UNUSED             = 2'd3;

    localparam logic [31:0] PROCESS_NOISE_RST      = 32'd655;
    localparam logic [31:0] MEASUREMENT_NOISE_RST  = 32'd65536;
    localparam logic [31:0] INITIAL_COVARIANCE_RST = 32'd65536;

    typedef enum logic
    {
        OP_MUL,
        OP_DIV
    } skf_op_t;

    typedef struct packed
    {
        logic    start;
        skf_op_t op;
    } skf_ctrl_t;

    typedef struct packed
    {
        logic busy;
        logic done;
    } skf_stat_t;

endpackage

[design/scalar_kalman_filter.sv]
// Top level of the scalar Kalman filter: register port, sequencer and state.
//
//  channel   direction  handshake          request contents
//  -------   ---------  -----------------  -------------------------------
//  input     in         in_valid/in_ready  sample (signed 16)
//  output    out        out_valid/out_ready estimate (signed Q16.16), gain
//  config    in         APB write/read     process/measurement noise, P0
//
// Each sample passes a setup state, then three passes of the shared shift-add/divide
// unit (gain division, estimate product, covariance product), each of 17 steps and
// a done pulse, and a final state that loads the output.
// in_ready is high only while the sequencer is idle; a finished result waits
// in the output register, and the next result waits until that one is taken.
// No clearing pass after reset.
module scalar_kalman_filter
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] sample,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] estimate,
    output logic [16:0]        gain
);

    typedef enum logic [2:0]
    {
        ST_IDLE,
        ST_PREP,
        ST_DIV,
        ST_MEST,
        ST_MCOV,
        ST_FINISH
    } state_t;

    state_t                      state_reg;
    logic [31:0]                 q_noise_reg;
    logic [31:0]                 r_noise_reg;
    logic [31:0]                 p_init_reg;
    logic [31:0]                 cov_reg;
    logic [31:0]                 fv_reg;
    logic [31:0]                 p1_reg;
    logic                        den_zero_reg;
    logic [32:0]                 err_reg;
    logic signed [15:0]          sample_reg;
    logic [skf_pkg::GAIN_W-1:0]  gain_reg;
    logic                        out_valid_reg;
    logic [31:0]                 est_out_reg;
    logic [skf_pkg::GAIN_W-1:0]  gain_out_reg;

    logic [32:0]                 p1_sum;
    logic [31:0]                 p1_sat;
    logic [32:0]                 den;
    logic [32:0]                 err_next;
    logic                        cfg_wr;
    logic [1:0]                  cfg_idx;

    skf_pkg::skf_ctrl_t          ctrl;
    skf_pkg::skf_stat_t          stat;
    logic [skf_pkg::OPA_W-1:0]   opa;
    logic [31:0]                 opb;
    logic [skf_pkg::ACC_W-1:0]   acc;
    logic [skf_pkg::GAIN_W-1:0]  quo;
    logic [skf_pkg::GAIN_W-1:0]  gain_div;

    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[3:2];
    assign pready  = 1'b1;

    always_comb
    begin
        unique case (cfg_idx)
            skf_pkg::REG_PROCESS_NOISE:      prdata = q_noise_reg;
            skf_pkg::REG_MEASUREMENT_NOISE:  prdata = r_noise_reg;
            skf_pkg::REG_INITIAL_COVARIANCE: prdata = p_init_reg;
            default:                         prdata = '0;
        endcase
    end

    assign p1_sum   = {1'b0, cov_reg} + {1'b0, q_noise_reg};
    assign p1_sat   = p1_sum[32] ? '1 : p1_sum[31:0];
    assign den      = {1'b0, p1_sat} + {1'b0, r_noise_reg};
    assign err_next = {sample_reg[15], sample_reg, 16'b0} - {fv_reg[31], fv_reg};
    assign gain_div = den_zero_reg ? '0 : quo;

    // drive the shared unit on each phase start
    always_comb
    begin
        ctrl.start = 1'b0;
        ctrl.op    = skf_pkg::OP_MUL;
        opa        = '0;
        opb        = '0;
        unique case (state_reg)
            ST_PREP:
            begin
                ctrl.start = 1'b1;
                ctrl.op    = skf_pkg::OP_DIV;
                opa        = {1'b0, den};
                opb        = p1_sat;
            end
            ST_DIV:
            begin
                ctrl.start = stat.done;
                opa        = {err_reg[32], err_reg};
                opb        = {15'b0, gain_div};
            end
            ST_MEST:
            begin
                ctrl.start = stat.done;
                opa        = {2'b0, p1_reg};
                opb        = {15'b0, skf_pkg::GAIN_ONE - gain_reg};
            end
            default:
            begin
                ctrl.start = 1'b0;
            end
        endcase
    end

    skf_iter_unit u_iter
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctrl  (ctrl),
        .opa   (opa),
        .opb   (opb),
        .stat  (stat),
        .acc   (acc),
        .quo   (quo)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            q_noise_reg   <= skf_pkg::PROCESS_NOISE_RST;
            r_noise_reg   <= skf_pkg::MEASUREMENT_NOISE_RST;
            p_init_reg    <= skf_pkg::INITIAL_COVARIANCE_RST;
            cov_reg       <= skf_pkg::INITIAL_COVARIANCE_RST;
            fv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && out_ready && (state_reg != ST_FINISH))
            begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr)
            begin
                unique case (cfg_idx)
                    skf_pkg::REG_PROCESS_NOISE:     q_noise_reg <= pwdata;
                    skf_pkg::REG_MEASUREMENT_NOISE: r_noise_reg <= pwdata;
                    skf_pkg::REG_INITIAL_COVARIANCE:
                    begin
                        p_init_reg <= pwdata;
                        cov_reg    <= pwdata;
                    end
                    default:
                    begin
                    end
                endcase
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        sample_reg <= sample;
                        state_reg  <= ST_PREP;
                    end
                end
                ST_PREP:
                begin
                    p1_reg       <= p1_sat;
                    den_zero_reg <= (den == '0);
                    err_reg      <= err_next;
                    state_reg    <= ST_DIV;
                end
                ST_DIV:
                begin
                    if (stat.done)
                    begin
                        gain_reg  <= gain_div;
                        state_reg <= ST_MEST;
                    end
                end
                ST_MEST:
                begin
                    if (stat.done)
                    begin
                        // floor of product / 2^16, wrapped to 32 bits
                        fv_reg    <= fv_reg + acc[47:16];
                        state_reg <= ST_MCOV;
                    end
                end
                ST_MCOV:
                begin
                    if (stat.done)
                    begin
                        cov_reg   <= acc[47:16];
                        state_reg <= ST_FINISH;
                    end
                end
                ST_FINISH:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        est_out_reg   <= fv_reg;
                        gain_out_reg  <= gain_reg;
                        out_valid_reg <= 1'b1;
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign estimate  = est_out_reg;
    assign gain      = gain_out_reg;

endmodule

[design/skf_iter_unit.sv]
// Shared shift-add multiplier and restoring divider, one bit per cycle.
module skf_iter_unit
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  skf_pkg::skf_ctrl_t            ctrl,
    input  logic [skf_pkg::OPA_W-1:0]     opa,
    input  logic [31:0]                   opb,
    output skf_pkg::skf_stat_t            stat,
    output logic [skf_pkg::ACC_W-1:0]     acc,
    output logic [skf_pkg::GAIN_W-1:0]    quo
);

    localparam int unsigned CNT_W = $clog2(skf_pkg::GAIN_W + 1);

    logic [skf_pkg::ACC_W-1:0]  acc_reg;
    logic [skf_pkg::GAIN_W-1:0] q_reg;
    logic [skf_pkg::OPA_W-1:0]  mcand_reg;
    skf_pkg::skf_op_t           op_reg;
    logic [CNT_W-1:0]           cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [skf_pkg::ACC_W-1:0]  shifted;
    logic [skf_pkg::ACC_W-1:0]  mcand_ext;
    logic [skf_pkg::ACC_W-1:0]  addend;
    logic [skf_pkg::ACC_W-1:0]  sum;
    logic                       in_bit;

    assign mcand_ext = {{(skf_pkg::ACC_W - skf_pkg::OPA_W){mcand_reg[skf_pkg::OPA_W-1]}},
                        mcand_reg};
    assign in_bit    = (op_reg == skf_pkg::OP_DIV) ? q_reg[skf_pkg::GAIN_W-1] : 1'b0;
    assign shifted   = {acc_reg[skf_pkg::ACC_W-2:0], in_bit};

    always_comb
    begin
        case (op_reg)
            skf_pkg::OP_DIV: addend = ~mcand_ext + 1'b1;
            default:         addend = q_reg[skf_pkg::GAIN_W-1] ? mcand_ext : '0;
        endcase
    end

    assign sum = shifted + addend;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            op_reg    <= skf_pkg::OP_MUL;
            acc_reg   <= '0;
            q_reg     <= '0;
            mcand_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (ctrl.start)
            begin
                busy_reg  <= 1'b1;
                cnt_reg   <= CNT_W'(skf_pkg::GAIN_W);
                op_reg    <= ctrl.op;
                mcand_reg <= opa;
                if (ctrl.op == skf_pkg::OP_DIV)
                begin
                    acc_reg <= {{(skf_pkg::ACC_W - 31){1'b0}}, opb[31:1]};
                    q_reg   <= {opb[0], {(skf_pkg::GAIN_W - 1){1'b0}}};
                end
                else
                begin
                    acc_reg <= '0;
                    q_reg   <= opb[skf_pkg::GAIN_W-1:0];
                end
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                if (op_reg == skf_pkg::OP_DIV)
                begin
                    // restoring step: keep the difference when it stays non-negative
                    if (!sum[skf_pkg::ACC_W-1])
                    begin
                        acc_reg <= sum;
                        q_reg   <= {q_reg[skf_pkg::GAIN_W-2:0], 1'b1};
                    end
                    else
                    begin
                        acc_reg <= shifted;
                        q_reg   <= {q_reg[skf_pkg::GAIN_W-2:0], 1'b0};
                    end
                end
                else
                begin
                    acc_reg <= sum;
                    q_reg   <= {q_reg[skf_pkg::GAIN_W-2:0], 1'b0};
                end
            end
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign acc       = acc_reg;
    assign quo       = q_reg;

endmodule

[sim/skf_checker.sv]
// Checker for the scalar Kalman filter: watches the ports, predicts each result and register read and compares.
`timescale 1ns / 100ps

module skf_checker
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic [31:0]        prdata,
    input  logic               pready,
    input  logic               in_valid,
    input  logic               in_ready,
    input  logic signed [15:0] sample,
    input  logic               out_valid,
    input  logic               out_ready,
    input  logic signed [31:0] estimate,
    input  logic [16:0]        gain,
    output int                 errors,
    output int                 pending
);

    typedef struct packed
    {
        logic signed [31:0] estimate;
        logic [16:0]        gain;
    } kf_out_t;

    logic [31:0]        q_noise;
    logic [31:0]        r_noise;
    logic [31:0]        p_init;
    logic [31:0]        cov_q;
    logic signed [31:0] est_q;

    kf_out_t            results_due[$];
    int                 result_idx;
    int                 fail_count;

    function automatic kf_out_t filter_sample(input logic signed [15:0] s);
        logic [32:0] p_sum;
        logic [31:0] p_pred;
        logic [32:0] denom;
        logic [63:0] gain_q;
        longint      err;
        longint      prod;
        longint      est_next;
        kf_out_t     res;
        p_sum  = {1'b0, cov_q} + {1'b0, q_noise};
        p_pred = p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
        denom  = {1'b0, p_pred} + {1'b0, r_noise};
        if (denom == 33'd0)
            gain_q = 64'd0;
        else
            gain_q = {16'd0, p_pred, 16'd0} / {31'd0, denom};
        if (gain_q > 64'(skf_pkg::GAIN_ONE))
            gain_q = 64'(skf_pkg::GAIN_ONE);
        err      = (longint'(s) <<< 16) - longint'(est_q);
        prod     = longint'(gain_q) * err;
        est_next = longint'(est_q) + (prod >>> 16);
        est_q    = 32'(est_next);
        cov_q    = 32'(((64'(skf_pkg::GAIN_ONE) - gain_q) * {32'd0, p_pred}) >> 16);
        res.estimate = est_q;
        res.gain     = gain_q[16:0];
        return res;
    endfunction

    function automatic logic [31:0] reg_value(input logic [1:0] idx);
        case (idx)
            skf_pkg::REG_PROCESS_NOISE:      return q_noise;
            skf_pkg::REG_MEASUREMENT_NOISE:  return r_noise;
            default:                         return p_init;
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        kf_out_t want;
        if (!rst_n)
        begin
            q_noise    = skf_pkg::PROCESS_NOISE_RST;
            r_noise    = skf_pkg::MEASUREMENT_NOISE_RST;
            p_init     = skf_pkg::INITIAL_COVARIANCE_RST;
            cov_q      = skf_pkg::INITIAL_COVARIANCE_RST;
            est_q      = '0;
            result_idx = 0;
            fail_count = 0;
            results_due.delete();
            errors  <= 0;
            pending <= 0;
        end
        else
        begin
            if (psel && penable && pready)
            begin
                if (pwrite)
                begin
                    case (paddr[3:2])
                        skf_pkg::REG_PROCESS_NOISE:      q_noise = pwdata;
                        skf_pkg::REG_MEASUREMENT_NOISE:  r_noise = pwdata;
                        skf_pkg::REG_INITIAL_COVARIANCE:
                        begin
                            p_init = pwdata;
                            cov_q  = pwdata;
                        end
                        default: ;
                    endcase
                end
                else if (paddr[3:2] != skf_pkg::REG_UNUSED &&
                         prdata !== reg_value(paddr[3:2]))
                begin
                    if (fail_count < 10)
                        $display("register read at %h: expected %h, got %h",
                                 paddr, reg_value(paddr[3:2]), prdata);
                    fail_count++;
                end
            end

            if (in_valid && in_ready)
                results_due.push_back(filter_sample(sample));

            if (out_valid && out_ready)
            begin
                if (results_due.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("result %0d: none expected, got estimate %h gain %h",
                                 result_idx, estimate, gain);
                    fail_count++;
                end
                else
                begin
                    want = results_due.pop_front();
                    if (estimate !== want.estimate || gain !== want.gain)
                    begin
                        if (fail_count < 10)
                            $display("result %0d: estimate exp %h got %h, gain exp %h got %h",
                                     result_idx, want.estimate, estimate, want.gain, gain);
                        fail_count++;
                    end
                end
                result_idx++;
            end

            errors  <= fail_count;
            pending <= results_due.size();
        end
    end

endmodule

[sim/tb_scalar_kalman_filter.sv]
// Testbench top for the scalar Kalman filter: stimulus, register setup and verdict.
`timescale 1ns / 100ps

module tb_scalar_kalman_filter;

    localparam int          CYCLE_LIMIT   = 2000000;
    localparam int          RANDOM_PHASES = 12;
    localparam int          PHASE_ITEMS   = 100;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               psel      = 1'b0;
    logic               penable   = 1'b0;
    logic               pwrite    = 1'b0;
    logic [3:0]         paddr     = '0;
    logic [31:0]        pwdata    = '0;
    logic [31:0]        prdata;
    logic               pready;
    logic               in_valid  = 1'b0;
    logic               in_ready;
    logic signed [15:0] sample    = '0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic signed [31:0] estimate;
    logic [16:0]        gain;

    int                 errors;
    int                 pending;

    int                 sender_idle_pct = 0;
    int                 recv_stall_pct  = 0;
    int                 signal_level    = 0;
    int                 n_samples       = 0;
    int                 n_settings      = 0;
    int                 cycle_count;

    scalar_kalman_filter uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .estimate  (estimate),
        .gain      (gain)
    );

    skf_checker u_checker
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .sample    (sample),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .estimate  (estimate),
        .gain      (gain),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // receiver backpressure, drawn each cycle
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic apb_write(input logic [1:0] idx, input logic [31:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_read(input logic [1:0] idx);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_filter(input logic [31:0] q, input logic [31:0] r, input logic [31:0] p0);
        apb_write(skf_pkg::REG_PROCESS_NOISE, q);
        apb_write(skf_pkg::REG_MEASUREMENT_NOISE, r);
        apb_write(skf_pkg::REG_INITIAL_COVARIANCE, p0);
        apb_read(skf_pkg::REG_PROCESS_NOISE);
        apb_read(skf_pkg::REG_MEASUREMENT_NOISE);
        apb_read(skf_pkg::REG_INITIAL_COVARIANCE);
        n_settings++;
    endtask

    task automatic push_sample(input logic signed [15:0] value);
        int gap;
        gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 70) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        sample   <= value;
        do @(posedge clk); while (!in_ready);
        n_samples++;
    endtask

    // all requests answered, block idle
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [31:0] pick_noise();
        case ($urandom_range(5))
            0:       return 32'd0;
            1:       return 32'hFFFF_FFFF;
            2:       return $urandom;
            3:       return $urandom_range(0, 32'h0010_0000);
            4:       return $urandom_range(1, 2000);
            default: return $urandom_range(0, 32'h0100_0000);
        endcase
    endfunction

    // a noisy, slowly drifting signal half the time, else full-range and extreme samples
    function automatic logic signed [15:0] pick_sample();
        int v;
        case ($urandom_range(9))
            0:       v = -32768;
            1:       v = 32767;
            2, 3, 4: v = $signed(16'($urandom));
            default:
            begin
                signal_level = signal_level + $urandom_range(0, 200) - 100;
                if (signal_level > 32767)
                    signal_level = 32767;
                if (signal_level < -32768)
                    signal_level = -32768;
                v = signal_level + $urandom_range(0, 64) - 32;
                if (v > 32767)
                    v = 32767;
                if (v < -32768)
                    v = -32768;
            end
        endcase
        return 16'(v);
    endfunction

    initial
    begin
        for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
            @(posedge clk);
        $display("timeout after %0d cycles, %0d results outstanding", cycle_count, pending);
        $display("[scalar_kalman_filter] ERROR");
        $finish;
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings, field extremes
        push_sample(16'sd0);
        push_sample(16'sd32767);
        push_sample(-16'sd32768);
        push_sample(-16'sd1);
        push_sample(16'sd1);
        push_sample(16'sd32767);
        drain();

        // zero denominator
        set_filter(32'd0, 32'd0, 32'd0);
        push_sample(16'sd100);
        push_sample(-16'sd32768);
        drain();

        // zero measurement noise
        set_filter(32'd0, 32'd0, 32'd65536);
        push_sample(16'sd32767);
        push_sample(-16'sd32768);
        push_sample(16'sd5);
        drain();

        // covariance saturation
        set_filter(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        push_sample(16'sd32767);
        push_sample(-16'sd32768);
        push_sample(16'sd0);
        drain();

        // write to an unmapped address is dropped
        apb_write(skf_pkg::REG_UNUSED, 32'h1234_5678);
        apb_read(skf_pkg::REG_PROCESS_NOISE);
        push_sample(16'sd1);
        push_sample(16'sd2);
        drain();

        set_filter(32'd0, 32'hFFFF_FFFF, 32'd1);
        push_sample(16'sd32767);
        push_sample(-16'sd32768);
        drain();

        set_filter(skf_pkg::PROCESS_NOISE_RST, skf_pkg::MEASUREMENT_NOISE_RST,
                   skf_pkg::INITIAL_COVARIANCE_RST);
        push_sample(16'sd1000);
        push_sample(-16'sd1000);
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            case (ph % 4)
                0:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 0;
                end
                1:
                begin
                    sender_idle_pct = 67;
                    recv_stall_pct  = 0;
                end
                2:
                begin
                    sender_idle_pct = 0;
                    recv_stall_pct  = 67;
                end
                default:
                begin
                    sender_idle_pct = 18;
                    recv_stall_pct  = 18;
                end
            endcase

            if (ph == 0 || $urandom_range(2) == 0)
                set_filter(pick_noise(), pick_noise(), pick_noise());
            else
            begin
                // partial update; a covariance restart keeps the estimate
                if ($urandom_range(1))
                    apb_write(skf_pkg::REG_INITIAL_COVARIANCE, pick_noise());
                if ($urandom_range(1))
                    apb_write(skf_pkg::REG_MEASUREMENT_NOISE, pick_noise());
                if ($urandom_range(1))
                    apb_write(skf_pkg::REG_PROCESS_NOISE, pick_noise());
                apb_write(skf_pkg::REG_UNUSED, $urandom);
                apb_read(skf_pkg::REG_INITIAL_COVARIANCE);
                n_settings++;
            end

            for (int k = 0; k < PHASE_ITEMS; k++)
                push_sample(pick_sample());
            drain();
        end

        sender_idle_pct = 0;
        recv_stall_pct  = 0;
        repeat (80) @(posedge clk);

        $display("checked %0d samples over %0d register settings, with zero noise,",
                 n_samples, n_settings);
        $display("zero denominator, saturated covariance and stalls on both channels");
        if (errors == 0 && pending == 0)
            $display("[scalar_kalman_filter] OK");
        else
            $display("[scalar_kalman_filter] ERROR");
        $finish;
    end

endmodule

[scalar_kalman_filter.f]
design/skf_pkg.sv
design/skf_iter_unit.sv
design/scalar_kalman_filter.sv
sim/skf_checker.sv
sim/tb_scalar_kalman_filter.sv
